// ----- hdl/rmsprop_pkg.sv -----
// rmsprop_pkg: shared types and constants for the rmsprop element update block
// no dependencies
package rmsprop_pkg;

  localparam int DataWidth = 32;

  localparam logic [1:0] RegLearningRate = 2'd0;
  localparam logic [1:0] RegDecayRate    = 2'd1;
  localparam logic [1:0] RegEpsilon      = 2'd2;

  typedef struct packed {
    logic signed [DataWidth-1:0] grad_value;
    logic [DataWidth-1:0]        old_mean_square;
  } rms_in_t;

  typedef struct packed {
    logic [DataWidth-1:0]        new_mean_square;
    logic signed [DataWidth-1:0] update_value;
  } rms_out_t;

  typedef struct packed {
    logic [15:0] learning_rate;
    logic [15:0] decay_rate;
    logic [15:0] epsilon;
  } rms_cfg_t;

endpackage

// ----- hdl/rmsprop_update_element_top.sv -----
// rmsprop_update_element_top: pipelined rmsprop element update, q16.16
// uses rmsprop_pkg, rmsprop_sqrt_stage, rmsprop_div_stage
//
// Usage:
//   in_valid/in_stall/in_data carry one element (gradient, old mean square).
//   out_valid/out_stall/out_data return the new mean square and the update.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write learning rate (0), decay (1),
//   epsilon (2); cfg_ready is always high, other indexes are ignored.
// Throughput: one element per cycle unless out_stall holds the pipeline; the pipeline is 28 register stages:
//   two for the mean square products and rounding, twelve for the square root
//   (two root bits per stage), one for the numerator and denominator, twelve
//   for the 48-bit quotient (four bits per stage) and one for sign/saturation.
// Reset: clears all stage valid bits and loads the register defaults.
// Stall: when out_stall is high and the last stage holds a result, the run of
//   full stages at the end holds its contents while earlier stages keep moving,
//   so bubbles are squeezed out; in_stall rises only once all 28 stages are full,
//   so no item is lost or repeated.
module rmsprop_update_element_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rmsprop_pkg::rms_in_t in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rmsprop_pkg::rms_out_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data
);
  import rmsprop_pkg::*;

  localparam int NStage = 28;

  rms_cfg_t cfg_r;
  logic [NStage-1:0] vld_r;
  logic [NStage-1:0] adv;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.learning_rate <= 16'd66;
      cfg_r.decay_rate    <= 16'd62259;
      cfg_r.epsilon       <= 16'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegLearningRate: cfg_r.learning_rate <= cfg_data;
        RegDecayRate:    cfg_r.decay_rate    <= cfg_data;
        RegEpsilon:      cfg_r.epsilon       <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage i loads when it is empty or moves on
  always_comb begin
    adv[NStage-1] = !vld_r[NStage-1] || !out_stall;
    for (int i = NStage - 2; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
  end
  assign in_stall = !adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= in_valid;
      for (int i = 1; i < NStage; i++) begin
        if (adv[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // stage 0: magnitude and products
  logic [31:0] gmag;
  logic        neg;
  logic [63:0] sq;
  assign neg  = in_data.grad_value[31];
  assign gmag = neg ? (32'd0 - in_data.grad_value) : in_data.grad_value;
  assign sq   = {32'd0, gmag} * {32'd0, gmag};

  logic [47:0] t1_r;
  logic [63:0] sq_r;
  logic [16:0] om_r;
  logic [31:0] gmag0_r;
  logic        neg0_r;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      t1_r    <= {16'd0, in_data.old_mean_square} * {32'd0, cfg_r.decay_rate};
      sq_r    <= sq;
      om_r    <= 17'h10000 - {1'b0, cfg_r.decay_rate};
      gmag0_r <= gmag;
      neg0_r  <= neg;
    end
  end

  // stage 1: gradient term, sum, round, saturate
  logic [64:0] term2;
  logic [65:0] sum;
  logic [49:0] msw;
  logic [31:0] ms;
  assign term2 = {1'b0, 16'd0, sq_r[63:16]} * {48'd0, om_r}
               + {32'd0, ({16'd0, sq_r[15:0]} * {16'd0, om_r}) >> 16};
  assign sum   = {18'd0, t1_r} + {1'b0, term2} + 66'h8000;
  assign msw   = sum[65:16];
  assign ms    = (msw[49:32] != '0) ? 32'hFFFF_FFFF : msw[31:0];

  logic [31:0] ms1_r;
  logic [31:0] gmag1_r;
  logic        neg1_r;
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      ms1_r   <= ms;
      gmag1_r <= gmag0_r;
      neg1_r  <= neg0_r;
    end
  end

  // stages 2..13: square root of ms << 16
  logic [47:0] rad_r  [12];
  logic [23:0] root_r [12];
  logic [47:0] rem_r  [12];
  logic [31:0] msp_r  [12];
  logic [31:0] gp_r   [12];
  logic        np_r   [12];
  logic [47:0] rad_o  [12];
  logic [23:0] root_o [12];
  logic [47:0] rem_o  [12];

  for (genvar s = 0; s < 12; s++) begin : g_sqrt
    if (s == 0) begin : g_first
      rmsprop_sqrt_stage u_sq (
        .rad_in ({ms1_r, 16'd0}), .root_in(24'd0), .rem_in(48'd0),
        .rad_out(rad_o[s]), .root_out(root_o[s]), .rem_out(rem_o[s])
      );
    end else begin : g_rest
      rmsprop_sqrt_stage u_sq (
        .rad_in (rad_r[s-1]), .root_in(root_r[s-1]), .rem_in(rem_r[s-1]),
        .rad_out(rad_o[s]), .root_out(root_o[s]), .rem_out(rem_o[s])
      );
    end
    always_ff @(posedge clk) begin
      if (adv[s+2]) begin
        rad_r[s]  <= rad_o[s];
        root_r[s] <= root_o[s];
        rem_r[s]  <= rem_o[s];
        msp_r[s]  <= (s == 0) ? ms1_r : msp_r[s == 0 ? 0 : s-1];
        gp_r[s]   <= (s == 0) ? gmag1_r : gp_r[s == 0 ? 0 : s-1];
        np_r[s]   <= (s == 0) ? neg1_r : np_r[s == 0 ? 0 : s-1];
      end
    end
  end

  // stage 14: numerator and denominator
  logic [47:0] num_r;
  logic [24:0] den_r;
  logic [31:0] ms14_r;
  logic        neg14_r;
  logic        gz14_r;
  always_ff @(posedge clk) begin
    if (adv[14]) begin
      num_r   <= {16'd0, gp_r[11]} * {32'd0, cfg_r.learning_rate};
      den_r   <= {1'b0, root_r[11]} + {9'd0, cfg_r.epsilon};
      ms14_r  <= msp_r[11];
      neg14_r <= np_r[11];
      gz14_r  <= (gp_r[11] == '0);
    end
  end

  // stages 15..26: division, four quotient bits each
  logic [47:0] dn_r  [12];
  logic [47:0] dq_r  [12];
  logic [25:0] dr_r  [12];
  logic [24:0] dd_r  [12];
  logic [31:0] dms_r [12];
  logic        dng_r [12];
  logic        dgz_r [12];
  logic [47:0] dn_o  [12];
  logic [47:0] dq_o  [12];
  logic [25:0] dr_o  [12];

  for (genvar s = 0; s < 12; s++) begin : g_div
    if (s == 0) begin : g_first
      rmsprop_div_stage u_dv (
        .num_in(num_r), .den(den_r), .quo_in(48'd0), .rem_in(26'd0),
        .num_out(dn_o[s]), .quo_out(dq_o[s]), .rem_out(dr_o[s])
      );
    end else begin : g_rest
      rmsprop_div_stage u_dv (
        .num_in(dn_r[s-1]), .den(dd_r[s-1]), .quo_in(dq_r[s-1]), .rem_in(dr_r[s-1]),
        .num_out(dn_o[s]), .quo_out(dq_o[s]), .rem_out(dr_o[s])
      );
    end
    always_ff @(posedge clk) begin
      if (adv[s+15]) begin
        dn_r[s]  <= dn_o[s];
        dq_r[s]  <= dq_o[s];
        dr_r[s]  <= dr_o[s];
        dd_r[s]  <= (s == 0) ? den_r : dd_r[s == 0 ? 0 : s-1];
        dms_r[s] <= (s == 0) ? ms14_r : dms_r[s == 0 ? 0 : s-1];
        dng_r[s] <= (s == 0) ? neg14_r : dng_r[s == 0 ? 0 : s-1];
        dgz_r[s] <= (s == 0) ? gz14_r : dgz_r[s == 0 ? 0 : s-1];
      end
    end
  end

  // stage 27: zero denominator, sign and saturation
  logic [47:0] q;
  logic [31:0] upd;
  assign q = dq_r[11];
  always_comb begin
    if (dd_r[11] == '0) begin
      if (dgz_r[11])      upd = 32'd0;
      else if (dng_r[11]) upd = 32'h8000_0000;
      else                upd = 32'h7FFF_FFFF;
    end else if (dng_r[11]) begin
      upd = (q > 48'h8000_0000) ? 32'h8000_0000 : (32'd0 - q[31:0]);
    end else begin
      upd = (q > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    end
  end

  rms_out_t res_r;
  always_ff @(posedge clk) begin
    if (adv[27]) begin
      res_r.new_mean_square <= dms_r[11];
      res_r.update_value    <= upd;
    end
  end

  assign out_valid = vld_r[NStage-1];
  assign out_data  = res_r;

`ifndef SYNTHESIS
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed under stall");
  a_back_press: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (vld_r == '1) && out_stall)
    else $error("input stalled with a free stage");
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");
`endif
endmodule

// ----- hdl/rmsprop_sqrt_stage.sv -----
// rmsprop_sqrt_stage: one pipelined step of restoring integer square root
// uses rmsprop_pkg; two result bits per stage
module rmsprop_sqrt_stage (
  input  logic [47:0] rad_in,
  input  logic [23:0] root_in,
  input  logic [47:0] rem_in,
  output logic [47:0] rad_out,
  output logic [23:0] root_out,
  output logic [47:0] rem_out
);
  import rmsprop_pkg::*;

  logic [49:0] r1;
  logic [49:0] t1;
  logic [23:0] q1;
  logic [49:0] r2;
  logic [49:0] t2;

  always_comb begin
    r1 = {rem_in, rad_in[47:46]};
    t1 = {24'd0, root_in, 2'b01};
    if (r1 >= t1) begin
      r1 = r1 - t1;
      q1 = {root_in[22:0], 1'b1};
    end else begin
      q1 = {root_in[22:0], 1'b0};
    end
    r2 = {r1[47:0], rad_in[45:44]};
    t2 = {24'd0, q1, 2'b01};
    if (r2 >= t2) begin
      r2 = r2 - t2;
      root_out = {q1[22:0], 1'b1};
    end else begin
      root_out = {q1[22:0], 1'b0};
    end
    rem_out = r2[47:0];
    rad_out = {rad_in[43:0], 4'd0};
  end
endmodule

// ----- hdl/rmsprop_div_stage.sv -----
// rmsprop_div_stage: four pipelined bits of restoring unsigned division
// uses rmsprop_pkg
module rmsprop_div_stage (
  input  logic [47:0] num_in,
  input  logic [24:0] den,
  input  logic [47:0] quo_in,
  input  logic [25:0] rem_in,
  output logic [47:0] num_out,
  output logic [47:0] quo_out,
  output logic [25:0] rem_out
);
  import rmsprop_pkg::*;

  logic [26:0] r;
  logic [47:0] q;
  logic [47:0] n;

  always_comb begin
    r = {1'b0, rem_in};
    q = quo_in;
    n = num_in;
    for (int k = 0; k < 4; k++) begin
      r = {r[25:0], n[47]};
      n = {n[46:0], 1'b0};
      if (r >= {2'b00, den}) begin
        r = r - {2'b00, den};
        q = {q[46:0], 1'b1};
      end else begin
        q = {q[46:0], 1'b0};
      end
    end
    rem_out = r[25:0];
    quo_out = q;
    num_out = n;
  end
endmodule

// ----- verif/tb.sv -----
// tb: self-checking bench for rmsprop_update_element_top
// depends on rmsprop_pkg and the rtl under hdl
`timescale 1ns / 1ps

module tb;
  import rmsprop_pkg::*;

  localparam int WatchdogLimit = 20000;
  localparam int DrainCycles   = 40;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  rms_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  rms_out_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  rms_in_t  pending_elems[$];
  rms_out_t expected_updates[$];
  logic [15:0] lr_model, decay_model, eps_model;
  int  errors = 0;
  int  idle_cycles = 0;
  int  hold_off = 0;
  bit  long_hold_done = 0;
  bit  feeding = 0;
  int  send_gap = 0;
  bit  in_taken = 0;

  rmsprop_update_element_top u_top (.*);

  always #6 clk = ~clk;

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic rms_out_t rmsprop_predict(rms_in_t x);
    logic [63:0] gmag, sq, one_minus, term2, sum, ms, den, q, pos_max, sign_bit;
    logic        neg;
    rms_out_t    r;
    sign_bit = 64'h8000_0000;
    pos_max  = 64'h7FFF_FFFF;
    neg  = x.grad_value[31];
    gmag = neg ? {32'd0, -x.grad_value} : {32'd0, x.grad_value};
    if (neg && gmag == 0) gmag = sign_bit;
    one_minus = 64'd65536 - decay_model;
    sq = gmag * gmag;
    term2 = (sq >> 16) * one_minus + (((sq & 64'hFFFF) * one_minus) >> 16);
    sum = {32'd0, x.old_mean_square} * decay_model + term2;
    ms = (sum + 64'h8000) >> 16;
    if (ms > 64'hFFFF_FFFF) ms = 64'hFFFF_FFFF;
    den = isqrt64(ms << 16) + eps_model;
    r.new_mean_square = ms[31:0];
    if (den == 0) begin
      r.update_value = gmag == 0 ? 32'd0 : (neg ? 32'h8000_0000 : 32'h7FFF_FFFF);
    end else begin
      q = (lr_model * gmag) / den;
      if (neg) begin
        if (q > sign_bit) q = sign_bit;
        r.update_value = -q[31:0];
      end else begin
        if (q > pos_max) q = pos_max;
        r.update_value = q[31:0];
      end
    end
    return r;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 3) != 0) return 0;
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // input transfer seen at the rising edge, used by the driver
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
  end

  // driver: a payload is held until its transfer
  always @(negedge clk) begin
    if (rst_n && feeding) begin
      if (!in_valid || in_taken) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_elems.size() > 0) begin
          in_data  <= pending_elems.pop_front();
          in_valid <= 1'b1;
          send_gap <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // prediction at acceptance
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      expected_updates.push_back(rmsprop_predict(in_data));
  end

  // receiver stall, with one long hold-off
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off  <= hold_off - 1;
      out_stall <= 1'b1;
    end else if (!long_hold_done && feeding && expected_updates.size() > 5) begin
      long_hold_done <= 1;
      hold_off  <= 200;
      out_stall <= 1'b1;
    end else begin
      out_stall <= pick_gap() != 0;
    end
  end

  // monitor
  always @(posedge clk) begin
    rms_out_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_updates.size() == 0) begin
        $display("%0t unexpected result ms=%h upd=%h", $time,
                 out_data.new_mean_square, out_data.update_value);
        errors = errors + 1;
      end else begin
        exp_r = expected_updates.pop_front();
        if (exp_r.new_mean_square !== out_data.new_mean_square) begin
          $display("%0t new_mean_square exp %h got %h", $time,
                   exp_r.new_mean_square, out_data.new_mean_square);
          errors = errors + 1;
        end
        if (exp_r.update_value !== out_data.update_value) begin
          $display("%0t update_value exp %h got %h", $time,
                   exp_r.update_value, out_data.update_value);
          errors = errors + 1;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !feeding)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("tb: errors");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      RegLearningRate: lr_model    = value;
      RegDecayRate:    decay_model = value;
      RegEpsilon:      eps_model   = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic rms_in_t rand_elem();
    rms_in_t x;
    case ($urandom_range(0, 5))
      0: x.grad_value = $urandom();
      1: x.grad_value = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      2: x.grad_value = $signed($urandom_range(0, 1 << 16)) - (1 << 15);
      default: x.grad_value = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
    endcase
    x.old_mean_square = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 1 << 20);
    return x;
  endfunction

  task automatic run_phase(input int count, input bit directed);
    rms_in_t x;
    if (directed) begin
      for (int i = 0; i < 16; i++) begin
        case (i % 8)
          0: x.grad_value = 32'sh7FFF_FFFF;
          1: x.grad_value = 32'sh8000_0000;
          2: x.grad_value = 0;
          3: x.grad_value = 1;
          4: x.grad_value = -1;
          5: x.grad_value = 32'sh0001_0000;
          6: x.grad_value = -32'sh0001_0000;
          default: x.grad_value = 32'sh5555_AAAA;
        endcase
        x.old_mean_square = (i < 8) ? 32'd0 : 32'hFFFF_FFFF;
        pending_elems.push_back(x);
      end
    end
    for (int i = 0; i < count; i++) pending_elems.push_back(rand_elem());
    feeding = 1;
    while (pending_elems.size() > 0 || in_valid || expected_updates.size() > 0)
      @(posedge clk);
    feeding = 0;
    repeat (DrainCycles) @(posedge clk);
  endtask

  initial begin
    lr_model = 16'd66;
    decay_model = 16'd62259;
    eps_model = 16'd1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    run_phase(150, 1);
    write_reg(RegLearningRate, 16'hFFFF);
    write_reg(RegDecayRate, 16'd0);
    write_reg(RegEpsilon, 16'd0);
    run_phase(150, 1);
    write_reg(RegLearningRate, 16'd0);
    write_reg(RegDecayRate, 16'hFFFF);
    write_reg(RegEpsilon, 16'hFFFF);
    write_reg(2'd3, 16'h1234);
    run_phase(120, 0);
    write_reg(RegLearningRate, 16'($urandom()));
    write_reg(RegDecayRate, 16'($urandom()));
    write_reg(RegEpsilon, 16'($urandom_range(0, 300)));
    run_phase(150, 0);
    if (errors == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule

// ----- rmsprop_update_element_top.f -----
hdl/rmsprop_pkg.sv
hdl/rmsprop_sqrt_stage.sv
hdl/rmsprop_div_stage.sv
hdl/rmsprop_update_element_top.sv
verif/tb.sv
